// ----- design/frame_lag_autocorrelation_detector_macros.svh -----
// Assertion macros for the frame-lag autocorrelation detector.
// Taken in by the top level; needs nothing else.
`ifndef FRAME_LAG_AUTOCORRELATION_DETECTOR_MACROS_SVH
`define FRAME_LAG_AUTOCORRELATION_DETECTOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define FLAD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FLAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/flad_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the frame-lag autocorrelation detector.
// No dependencies; used by the channel interfaces and the top level.
package flad_pkg;

	// default sizing of the stores and samples
	localparam int MAX_LAG_DEF     = 32768;
	localparam int MAX_WINDOW_DEF  = 2048;
	localparam int SAMPLE_BITS_DEF = 12;

	// configuration registers
	localparam int LAG_REG_W    = 16;
	localparam int WIN_REG_W    = 12;
	localparam int SEARCH_REG_W = 16;
	localparam int POW_W        = 63;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 63;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LAG_LEN,
		REG_WINDOW_LEN,
		REG_SEARCH_LEN,
		REG_PEAK_THRESHOLD
	} cfg_reg_t;

	localparam logic [LAG_REG_W-1:0]    LAG_RST    = 16'd19200;
	localparam logic [WIN_REG_W-1:0]    WIN_RST    = 12'd1920;
	localparam logic [SEARCH_REG_W-1:0] SEARCH_RST = 16'd19200;
	localparam logic [POW_W-1:0]        THR_RST    = '0;

	localparam logic [SEARCH_REG_W-1:0] SEARCH_MAX = 16'd32768;

	// x / 10 == (x * 52429) >> 19 for every x below 81920
	localparam logic [LAG_REG_W-1:0] DIV10_MUL   = 16'd52429;
	localparam int                   DIV10_SHIFT = 19;

	// datapath
	localparam int SUM_W       = 36;
	localparam int SCORE_SHIFT = 4;
	localparam int MAG_W       = SUM_W - SCORE_SHIFT;
	localparam logic [POW_W-1:0] POW_MAX = {POW_W{1'b1}};

	localparam int             CNT_W   = 17;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam int OFS_W = 15;

	// cycles the sample input is held off after a register write
	localparam logic [1:0] CFG_SETTLE = 2'd2;

	// result status
	localparam int STATUS_W = 2;
	typedef enum logic [STATUS_W-1:0] {
		STATUS_DETECTED = 2'd0,
		STATUS_BELOW    = 2'd1,
		STATUS_SHORT    = 2'd2
	} status_t;

endpackage

// ----- design/flad_if.sv -----
`timescale 1ns / 1ps
// Request channels of the frame-lag autocorrelation detector:
// sample input, result output and register write. Depends on flad_pkg.

interface flad_smp_if #(
	parameter int SAMPLE_BITS = flad_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_re;
	logic signed [SAMPLE_BITS-1:0] sample_im;
	logic                          last_sample;

	modport source (output valid, output sample_re, output sample_im,
		output last_sample, input ready);
	modport sink (input valid, input sample_re, input sample_im,
		input last_sample, output ready);
endinterface

interface flad_res_if;
	logic                                valid;
	logic                                ready;
	logic [flad_pkg::STATUS_W-1:0]       status;
	logic [flad_pkg::OFS_W-1:0]          frame_start;
	logic [flad_pkg::POW_W-1:0]          peak_power;

	modport source (output valid, output status, output frame_start,
		output peak_power, input ready);
	modport sink (input valid, input status, input frame_start,
		input peak_power, output ready);
endinterface

interface flad_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [flad_pkg::CFG_IDX_W-1:0]    index;
	logic [flad_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/frame_lag_autocorrelation_detector.sv -----
`timescale 1ns / 1ps
// Frame-lag autocorrelation detector, top level.
// Depends on flad_pkg, the channel interfaces in flad_if.sv and the macro header.

// Searches a block of complex samples for the offset whose window of lagged
// products r[t+n]*conj(r[t+n+L]) has the largest power, and reports status,
// offset and power on the request that carries the last-sample flag. A sample
// whose window is scored passes through accept/read, multiply, accumulate,
// square and compare; before the lag has filled it stops after multiply,
// and where its window is not scored, after accumulate. The flagged sample
// adds a step that loads the result register. The sequence is set by the
// read-modify-write of the delay and product memories, each read through a
// registered output, followed by the two multiplier stages. The result
// register lets the next block start while a result waits. No clearing pass
// follows reset. After a register write the sample input is held off while
// the effective lag, window and search length settle.

`include "frame_lag_autocorrelation_detector_macros.svh"

module frame_lag_autocorrelation_detector #(
	parameter int MAX_LAG     = flad_pkg::MAX_LAG_DEF,
	parameter int MAX_WINDOW  = flad_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = flad_pkg::SAMPLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	flad_smp_if.sink    smp,
	flad_res_if.source  res,
	flad_cfg_if.sink    cfg
);

	localparam int SB      = SAMPLE_BITS;
	localparam int PW      = 2 * SB + 1;
	localparam int DLY_AW  = $clog2(MAX_LAG);
	localparam int PWIN_AW = $clog2(MAX_WINDOW);
	localparam int LAG_W   = $clog2(MAX_LAG + 1);
	localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
	localparam int DPW     = LAG_W + 1;
	localparam int PPW     = WIN_W + 1;
	localparam int CNT_W   = flad_pkg::CNT_W;
	localparam int EXT_W   = flad_pkg::LAG_REG_W + 1;
	localparam int LDIV_W  = EXT_W - 3;
	localparam int SUM_W   = flad_pkg::SUM_W;
	localparam int MAG_W   = flad_pkg::MAG_W;
	localparam int POW_W   = flad_pkg::POW_W;
	localparam int OFS_W   = flad_pkg::OFS_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_SQ,
		ST_CMP,
		ST_FIN
	} state_t;

	// configuration
	logic [flad_pkg::LAG_REG_W-1:0]    lag_q;
	logic [flad_pkg::WIN_REG_W-1:0]    win_q;
	logic [flad_pkg::SEARCH_REG_W-1:0] search_q;
	logic [POW_W-1:0]                  thr_q;
	logic [1:0]                        settle_q;
	logic                              cfg_wr;

	logic [LAG_W-1:0]                  eff_lag_q;
	logic [LDIV_W-1:0]                 lag_div_q;
	logic [WIN_W-1:0]                  eff_win_q;
	logic [flad_pkg::SEARCH_REG_W-1:0] eff_search_q;
	logic [EXT_W-1:0]                  lag_sat;
	logic [2*EXT_W-1:0]                lag_prod;
	logic [EXT_W-1:0]                  win0, win1, win2;

	// control
	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DLY_AW-1:0] dly_wp_q;
	logic [PWIN_AW-1:0] pwp_q;
	logic              has_lag_s1;
	logic              last_s1;
	logic              sub_s2;
	logic              score_s2;
	logic              smp_acc;
	logic              fin_go;

	// datapath
	logic signed [SB-1:0]    re_s1, im_s1;
	logic [CNT_W-1:0]        j_s1;
	logic [2*SB-1:0]         dly_rd_s1;
	logic [2*PW-1:0]         prd_s1;
	logic [PW-1:0]           pre_s2, pim_s2;
	logic [OFS_W-1:0]        t_s2;
	logic [2*MAG_W-1:0]      sq_re_s3, sq_im_s3;
	logic [SUM_W-1:0]        sum_re_q, sum_im_q;
	logic [POW_W-1:0]        best_q;
	logic [OFS_W-1:0]        best_ofs_q;

	// result register
	logic                           out_valid_q;
	logic [flad_pkg::STATUS_W-1:0]  out_status_q;
	logic [OFS_W-1:0]               out_start_q;
	logic [POW_W-1:0]               out_power_q;

	// memories
	logic [2*SB-1:0] dly_mem [MAX_LAG];
	logic [2*PW-1:0] pwin_mem [MAX_WINDOW];
	logic [DLY_AW-1:0]  dly_ra;
	logic [PWIN_AW-1:0] pwin_ra;
	logic [DPW-1:0]     dly_ra_x, dly_wp_x, dly_lag_x;
	logic [PPW-1:0]     pwin_ra_x, pwp_x, pwin_w_x;
	logic               dly_we, pwin_we;

	// combinational helpers
	logic signed [SB-1:0]   are, aim;
	logic signed [2*SB-1:0] m_rr, m_ii, m_ir, m_ri;
	logic [CNT_W:0]         jp1_x, w_x, t_x, j_x;
	logic                   score_x;
	logic [SUM_W-1:0]       old_re_x, old_im_x, pre_x, pim_x;
	logic [MAG_W-1:0]       sh_re, sh_im, mag_re, mag_im;
	logic [2*MAG_W-1:0]     pow_sum;
	logic [POW_W-1:0]       pow_x;
	logic                   short_x;

	assign cfg_wr    = cfg.valid && cfg.ready;
	assign cfg.ready = 1'b1;
	assign smp.ready = (state_q == ST_IDLE) && (settle_q == 2'd0);
	assign smp_acc   = smp.valid && smp.ready;
	assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || res.ready);

	assign res.valid       = out_valid_q;
	assign res.status      = out_status_q;
	assign res.frame_start = out_start_q;
	assign res.peak_power  = out_power_q;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lag_q    <= flad_pkg::LAG_RST;
			win_q    <= flad_pkg::WIN_RST;
			search_q <= flad_pkg::SEARCH_RST;
			thr_q    <= flad_pkg::THR_RST;
			settle_q <= flad_pkg::CFG_SETTLE;
		end else begin
			if (cfg_wr) begin
				settle_q <= flad_pkg::CFG_SETTLE;
				case (flad_pkg::cfg_reg_t'(cfg.index))
					flad_pkg::REG_LAG_LEN: begin
						lag_q <= cfg.data[flad_pkg::LAG_REG_W-1:0];
					end
					flad_pkg::REG_WINDOW_LEN: begin
						win_q <= cfg.data[flad_pkg::WIN_REG_W-1:0];
					end
					flad_pkg::REG_SEARCH_LEN: begin
						search_q <= cfg.data[flad_pkg::SEARCH_REG_W-1:0];
					end
					flad_pkg::REG_PEAK_THRESHOLD: begin
						thr_q <= cfg.data[POW_W-1:0];
					end
					default: begin
					end
				endcase
			end else if (settle_q != 2'd0) begin
				settle_q <= settle_q - 2'd1;
			end
		end
	end

	// effective lag, window and search length, two register levels
	always_comb begin
		if (lag_q == '0) begin
			lag_sat = EXT_W'(1);
		end else if (EXT_W'(lag_q) > EXT_W'(MAX_LAG)) begin
			lag_sat = EXT_W'(MAX_LAG);
		end else begin
			lag_sat = EXT_W'(lag_q);
		end
		lag_prod = lag_sat * EXT_W'(flad_pkg::DIV10_MUL);

		win0 = (win_q == '0) ? EXT_W'(1) : EXT_W'(win_q);
		if (win0 > EXT_W'(eff_lag_q)) begin
			win1 = (lag_div_q == '0) ? EXT_W'(1) : EXT_W'(lag_div_q);
		end else begin
			win1 = win0;
		end
		win2 = (win1 > EXT_W'(MAX_WINDOW)) ? EXT_W'(MAX_WINDOW) : win1;
	end

	always_ff @(posedge clk) begin
		eff_lag_q    <= LAG_W'(lag_sat);
		lag_div_q    <= lag_prod[flad_pkg::DIV10_SHIFT +: LDIV_W];
		eff_win_q    <= WIN_W'(win2);
		eff_search_q <= (search_q > flad_pkg::SEARCH_MAX) ? flad_pkg::SEARCH_MAX : search_q;
	end

	// ---------------- memory addressing ----------------
	always_comb begin
		dly_wp_x  = DPW'(dly_wp_q);
		dly_lag_x = DPW'(eff_lag_q);
		if (dly_wp_x >= dly_lag_x) begin
			dly_ra_x = dly_wp_x - dly_lag_x;
		end else begin
			dly_ra_x = dly_wp_x + DPW'(MAX_LAG) - dly_lag_x;
		end
		dly_ra = dly_ra_x[DLY_AW-1:0];

		pwp_x    = PPW'(pwp_q);
		pwin_w_x = PPW'(eff_win_q);
		if (pwp_x >= pwin_w_x) begin
			pwin_ra_x = pwp_x - pwin_w_x;
		end else begin
			pwin_ra_x = pwp_x + PPW'(MAX_WINDOW) - pwin_w_x;
		end
		pwin_ra = pwin_ra_x[PWIN_AW-1:0];
	end

	assign dly_we  = (state_q == ST_MUL);
	assign pwin_we = (state_q == ST_ACC);

	always_ff @(posedge clk) begin
		if (dly_we) begin
			dly_mem[dly_wp_q] <= {re_s1, im_s1};
		end
		if (smp_acc) begin
			dly_rd_s1 <= dly_mem[dly_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (pwin_we) begin
			pwin_mem[pwp_q] <= {pre_s2, pim_s2};
		end
		if (smp_acc) begin
			prd_s1 <= pwin_mem[pwin_ra];
		end
	end

	// ---------------- datapath ----------------
	always_comb begin
		are  = dly_rd_s1[2*SB-1:SB];
		aim  = dly_rd_s1[SB-1:0];
		m_rr = are * re_s1;
		m_ii = aim * im_s1;
		m_ir = aim * re_s1;
		m_ri = are * im_s1;

		j_x     = (CNT_W+1)'(j_s1);
		jp1_x   = j_x + (CNT_W+1)'(1);
		w_x     = (CNT_W+1)'(eff_win_q);
		t_x     = jp1_x - w_x;
		score_x = (jp1_x >= w_x) && (t_x < (CNT_W+1)'(eff_search_q));

		// sign-extend stored and new products to the accumulator width
		old_re_x = {{(SUM_W-PW){prd_s1[2*PW-1]}}, prd_s1[2*PW-1:PW]};
		old_im_x = {{(SUM_W-PW){prd_s1[PW-1]}}, prd_s1[PW-1:0]};
		pre_x    = {{(SUM_W-PW){pre_s2[PW-1]}}, pre_s2};
		pim_x    = {{(SUM_W-PW){pim_s2[PW-1]}}, pim_s2};

		// arithmetic shift then magnitude; the most negative value maps to 2^(MAG_W-1)
		sh_re  = sum_re_q[SUM_W-1:flad_pkg::SCORE_SHIFT];
		sh_im  = sum_im_q[SUM_W-1:flad_pkg::SCORE_SHIFT];
		mag_re = sh_re[MAG_W-1] ? (~sh_re + MAG_W'(1)) : sh_re;
		mag_im = sh_im[MAG_W-1] ? (~sh_im + MAG_W'(1)) : sh_im;

		pow_sum = sq_re_s3 + sq_im_s3;
		pow_x   = pow_sum[2*MAG_W-1] ? flad_pkg::POW_MAX : pow_sum[POW_W-1:0];

		short_x = (CNT_W+1)'(cnt_q) < ((CNT_W+1)'(eff_lag_q) << 1);
	end

	always_ff @(posedge clk) begin
		if (smp_acc) begin
			re_s1 <= smp.sample_re;
			im_s1 <= smp.sample_im;
			j_s1  <= cnt_q - CNT_W'(eff_lag_q);
		end
		if (state_q == ST_MUL) begin
			pre_s2 <= {m_rr[2*SB-1], m_rr} + {m_ii[2*SB-1], m_ii};
			pim_s2 <= {m_ir[2*SB-1], m_ir} - {m_ri[2*SB-1], m_ri};
			t_s2   <= t_x[OFS_W-1:0];
		end
		if (state_q == ST_SQ) begin
			sq_re_s3 <= (2*MAG_W)'(mag_re) * (2*MAG_W)'(mag_re);
			sq_im_s3 <= (2*MAG_W)'(mag_im) * (2*MAG_W)'(mag_im);
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			dly_wp_q     <= '0;
			pwp_q        <= '0;
			has_lag_s1   <= 1'b0;
			last_s1      <= 1'b0;
			sub_s2       <= 1'b0;
			score_s2     <= 1'b0;
			sum_re_q     <= '0;
			sum_im_q     <= '0;
			best_q       <= '0;
			best_ofs_q   <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= '0;
			out_start_q  <= '0;
			out_power_q  <= '0;
		end else begin
			if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (smp_acc) begin
						last_s1    <= smp.last_sample;
						has_lag_s1 <= cnt_q >= CNT_W'(eff_lag_q);
						if (cnt_q != flad_pkg::CNT_MAX) begin
							state_q <= ST_MUL;
						end else if (smp.last_sample) begin
							// saturated count: only the flag matters
							state_q <= ST_FIN;
						end
					end
				end
				ST_MUL: begin
					cnt_q    <= cnt_q + CNT_W'(1);
					dly_wp_q <= (dly_wp_q == DLY_AW'(MAX_LAG - 1)) ? '0
						: dly_wp_q + DLY_AW'(1);
					sub_s2   <= j_x >= w_x;
					score_s2 <= score_x;
					if (has_lag_s1) begin
						state_q <= ST_ACC;
					end else begin
						state_q <= last_s1 ? ST_FIN : ST_IDLE;
					end
				end
				ST_ACC: begin
					sum_re_q <= sum_re_q - (sub_s2 ? old_re_x : '0) + pre_x;
					sum_im_q <= sum_im_q - (sub_s2 ? old_im_x : '0) + pim_x;
					pwp_q    <= (pwp_q == PWIN_AW'(MAX_WINDOW - 1)) ? '0
						: pwp_q + PWIN_AW'(1);
					if (score_s2) begin
						state_q <= ST_SQ;
					end else begin
						state_q <= last_s1 ? ST_FIN : ST_IDLE;
					end
				end
				ST_SQ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					// strict compare keeps the first offset of equal peaks
					if (pow_x > best_q) begin
						best_q     <= pow_x;
						best_ofs_q <= t_s2;
					end
					state_q <= last_s1 ? ST_FIN : ST_IDLE;
				end
				ST_FIN: begin
					if (fin_go) begin
						out_valid_q <= 1'b1;
						if (short_x) begin
							out_status_q <= flad_pkg::STATUS_SHORT;
							out_start_q  <= '0;
							out_power_q  <= '0;
						end else if (best_q < thr_q) begin
							out_status_q <= flad_pkg::STATUS_BELOW;
							out_start_q  <= '0;
							out_power_q  <= best_q;
						end else begin
							out_status_q <= flad_pkg::STATUS_DETECTED;
							out_start_q  <= best_ofs_q;
							out_power_q  <= best_q;
						end
						sum_re_q   <= '0;
						sum_im_q   <= '0;
						best_q     <= '0;
						best_ofs_q <= '0;
						cnt_q      <= '0;
						dly_wp_q   <= '0;
						pwp_q      <= '0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ---------------- assertions ----------------
	`FLAD_ASSERT_NEXT(a_cfg_holds_off_samples, clk, arst_n, cfg_wr, !smp_acc, "sample taken right after register write")
	`FLAD_ASSERT_SAME(a_window_within_lag, clk, arst_n, settle_q == 2'd0, (eff_win_q != '0) && (eff_win_q <= eff_lag_q), "effective window out of range")
	`FLAD_ASSERT_NEXT(a_peak_monotonic, clk, arst_n, state_q != ST_FIN, best_q >= $past(best_q), "peak power dropped inside a block")
	`FLAD_ASSERT_NEXT(a_block_cleared, clk, arst_n, fin_go, out_valid_q && (cnt_q == '0) && (best_q == '0), "block state not cleared after result")

endmodule

// ----- bench/frame_lag_autocorrelation_detector_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the frame-lag autocorrelation detector: directed
// and random sample blocks, with results checked against an in-bench model.
// Depends on flad_pkg, the channel interfaces in flad_if.sv and the top level.

module frame_lag_autocorrelation_detector_test;
	import flad_pkg::*;

	localparam int          QUIET_CYCLES = 16;
	localparam int          LIMIT        = 4_000_000;
	localparam int          PAT_DEPTH    = 4096;
	localparam int unsigned RANDOM_ITEMS = 1350;
	localparam int unsigned RANDOM_RPTS  = 40;

	typedef logic signed [SAMPLE_BITS_DEF-1:0] smp_t;

	typedef struct {
		status_t          status;
		logic [OFS_W-1:0] frame_start;
		logic [POW_W-1:0] peak_power;
	} frame_report_t;

	logic clk = 1'b0;
	logic arst_n;

	flad_smp_if smp_ch ();
	flad_res_if res_ch ();
	flad_cfg_if cfg_ch ();

	frame_lag_autocorrelation_detector u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// register shadow
	logic [LAG_REG_W-1:0]    lag_reg    = LAG_RST;
	logic [WIN_REG_W-1:0]    win_reg    = WIN_RST;
	logic [SEARCH_REG_W-1:0] search_reg = SEARCH_RST;
	logic [POW_W-1:0]        thr_reg    = THR_RST;

	// correlator model state
	int                      dly_re [MAX_LAG_DEF];
	int                      dly_im [MAX_LAG_DEF];
	longint                  prod_re [MAX_WINDOW_DEF];
	longint                  prod_im [MAX_WINDOW_DEF];
	logic signed [SUM_W-1:0] acc_re = '0;
	logic signed [SUM_W-1:0] acc_im = '0;
	logic [POW_W-1:0]        top_power = '0;
	logic [OFS_W-1:0]        top_offset = '0;
	int unsigned             smp_count = 0;

	frame_report_t pending_reports[$];
	int            mismatches = 0;
	int            cycle_count = 0;
	int unsigned   reports_seen = 0;

	// sender pacing
	bit steady = 1'b0;
	int burst_left = 0;

	smp_t base_re [PAT_DEPTH];
	smp_t base_im [PAT_DEPTH];

	function automatic int unsigned eff_lag();
		int unsigned l;
		l = lag_reg;
		if (l == 0) l = 1;
		if (l > MAX_LAG_DEF) l = MAX_LAG_DEF;
		return l;
	endfunction

	function automatic longint unsigned shifted_square(input logic signed [SUM_W-1:0] acc);
		longint s;
		s = acc >>> SCORE_SHIFT;
		if (s < 0) s = -s;
		return longint'(s) * longint'(s);
	endfunction

	task automatic correlate_sample(input smp_t re, input smp_t im, input logic last);
		int unsigned       l, w, srch, k, j, t;
		longint            pre, pim;
		longint unsigned   p;
		frame_report_t     rpt;
		l = eff_lag();
		w = win_reg;
		if (w == 0) w = 1;
		if (w > l) w = l / 10;
		if (w == 0) w = 1;
		if (w > MAX_WINDOW_DEF) w = MAX_WINDOW_DEF;
		srch = search_reg;
		if (srch > SEARCH_MAX) srch = SEARCH_MAX;

		if (smp_count < CNT_MAX) begin
			k = smp_count;
			if (k >= l) begin
				j = k - l;
				pre = longint'(dly_re[j % MAX_LAG_DEF]) * re + longint'(dly_im[j % MAX_LAG_DEF]) * im;
				pim = longint'(dly_im[j % MAX_LAG_DEF]) * re - longint'(dly_re[j % MAX_LAG_DEF]) * im;
				if (j >= w) begin
					acc_re = acc_re - prod_re[(j - w) % MAX_WINDOW_DEF];
					acc_im = acc_im - prod_im[(j - w) % MAX_WINDOW_DEF];
				end
				acc_re = acc_re + pre;
				acc_im = acc_im + pim;
				prod_re[j % MAX_WINDOW_DEF] = pre;
				prod_im[j % MAX_WINDOW_DEF] = pim;
				if (j + 1 >= w) begin
					t = j + 1 - w;
					if (t < srch) begin
						p = shifted_square(acc_re) + shifted_square(acc_im);
						if (p > POW_MAX) p = POW_MAX;
						// strict compare keeps the first offset on ties
						if (p > top_power) begin
							top_power = p;
							top_offset = t;
						end
					end
				end
			end
			dly_re[k % MAX_LAG_DEF] = re;
			dly_im[k % MAX_LAG_DEF] = im;
			smp_count = k + 1;
		end

		if (last) begin
			if (smp_count < 2 * l) begin
				rpt.status = STATUS_SHORT;
				rpt.frame_start = '0;
				rpt.peak_power = '0;
			end else if (top_power < thr_reg) begin
				rpt.status = STATUS_BELOW;
				rpt.frame_start = '0;
				rpt.peak_power = top_power;
			end else begin
				rpt.status = STATUS_DETECTED;
				rpt.frame_start = top_offset;
				rpt.peak_power = top_power;
			end
			pending_reports.push_back(rpt);
			acc_re = '0;
			acc_im = '0;
			top_power = '0;
			top_offset = '0;
			smp_count = 0;
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// leaves valid high so that the next request can follow at once
	task automatic send_sample(input smp_t re, input smp_t im, input logic last);
		int gap;
		if (!steady && burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4);
			smp_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left != 0) burst_left--;
		smp_ch.valid       <= 1'b1;
		smp_ch.sample_re   <= re;
		smp_ch.sample_im   <= im;
		smp_ch.last_sample <= last;
		@(posedge clk);
		while (!smp_ch.ready) @(posedge clk);
		correlate_sample(re, im, last);
	endtask

	// random samples, turning periodic with the current lag from echo_start on when periodic is set and the lag fits
	task automatic send_block(input int unsigned len, input int unsigned echo_start,
			input bit periodic, input int unsigned noise_mask);
		int unsigned period, idx;
		smp_t        re, im;
		period = eff_lag();
		if (period > PAT_DEPTH) periodic = 1'b0;
		if (periodic) begin
			for (int unsigned i = 0; i < period; i++) begin
				base_re[i] = $urandom();
				base_im[i] = $urandom();
			end
		end
		for (int unsigned k = 0; k < len; k++) begin
			if (periodic && k >= echo_start) begin
				idx = (k - echo_start) % period;
				re = base_re[idx] ^ smp_t'($urandom_range(0, noise_mask));
				im = base_im[idx] ^ smp_t'($urandom_range(0, noise_mask));
			end else begin
				re = $urandom();
				im = $urandom();
			end
			send_sample(re, im, k == len - 1);
		end
	endtask

	task automatic wait_quiet();
		smp_ch.valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			REG_LAG_LEN:        lag_reg    = value[LAG_REG_W-1:0];
			REG_WINDOW_LEN:     win_reg    = value[WIN_REG_W-1:0];
			REG_SEARCH_LEN:     search_reg = value[SEARCH_REG_W-1:0];
			REG_PEAK_THRESHOLD: thr_reg    = value[POW_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_config(input logic [LAG_REG_W-1:0] lag, input logic [WIN_REG_W-1:0] win,
			input logic [SEARCH_REG_W-1:0] srch, input logic [POW_W-1:0] thr);
		wait_quiet();
		write_reg(REG_LAG_LEN, lag);
		write_reg(REG_WINDOW_LEN, win);
		write_reg(REG_SEARCH_LEN, srch);
		write_reg(REG_PEAK_THRESHOLD, thr);
		cfg_ch.valid <= 1'b0;
	endtask

	// reset values: a 19200 lag makes any short block report too short
	task automatic check_reset_defaults();
		send_sample(-12'sd2048, 12'sd2047, 1'b0);
		send_sample(12'sd2047, -12'sd2048, 1'b0);
		send_sample(12'sd0, -12'sd1, 1'b1);
	endtask

	// zero lag, zero window, zero search; zero threshold detects with no score
	task automatic check_degenerate_settings();
		apply_config('0, '0, '0, '0);
		send_sample(-12'sd2048, -12'sd2048, 1'b0);
		send_sample(12'sd2047, 12'sd2047, 1'b0);
		send_sample(-12'sd1, 12'sd0, 1'b0);
		send_sample(12'sd1, -12'sd2048, 1'b1);
		apply_config('0, '0, '0, 63'd1);
		send_sample(12'sd2047, -12'sd1, 1'b0);
		send_sample(-12'sd2048, 12'sd2047, 1'b0);
		send_sample(12'sd0, 12'sd0, 1'b1);
	endtask

	// saturated lag with a short block, then a window far beyond a tiny lag
	task automatic check_max_lag_and_wide_window();
		apply_config('1, '1, '1, POW_MAX);
		send_sample(12'sd2047, 12'sd2047, 1'b0);
		send_sample(-12'sd2048, -12'sd2048, 1'b1);
		apply_config(16'd5, '1, '1, POW_MAX);
		send_block(12, 0, 1'b0, 0);
	endtask

	task automatic check_saturated_window();
		apply_config(16'd2200, 12'd2100, 16'd200, '0);
		send_block(4450, 300, 1'b1, 63);
	endtask

	// sample counter saturates; later samples only carry the end flag
	task automatic check_count_saturation();
		apply_config(16'd3, 12'd2, '1, '0);
		steady = 1'b1;
		send_block(CNT_MAX + 4, 20000, 1'b1, 255);
		steady = 1'b0;
	endtask

	task automatic check_random_blocks();
		int unsigned            items, blocks_left, l, w, len, mode;
		logic [LAG_REG_W-1:0]   lag;
		logic [WIN_REG_W-1:0]   win;
		logic [SEARCH_REG_W-1:0] srch;
		logic [POW_W-1:0]       thr;
		items = 0;
		blocks_left = 0;
		reports_seen = 0;
		while (items < RANDOM_ITEMS || reports_seen < RANDOM_RPTS) begin
			if (blocks_left == 0) begin
				lag = ($urandom_range(0, 7) == 0) ? 16'd0 : $urandom_range(1, 24);
				l = (lag == 0) ? 1 : lag;
				win = ($urandom_range(0, 9) == 0) ? 12'd4095 : $urandom_range(0, l + l / 2 + 2);
				case ($urandom_range(0, 9))
					0:       srch = '0;
					1:       srch = '1;
					default: srch = $urandom_range(1, 3 * l + 4);
				endcase
				case ($urandom_range(0, 5))
					0:       thr = '0;
					1:       thr = POW_MAX;
					default: thr = {$urandom(), $urandom()} >> $urandom_range(8, 50);
				endcase
				apply_config(lag, win, srch, thr);
				blocks_left = $urandom_range(1, 3);
			end
			blocks_left--;
			w = (win == 0) ? 1 : win;
			mode = $urandom_range(0, 19);
			if (mode < 14) len = 2 * l + $urandom_range(0, l + 8);
			else if (mode < 17) len = $urandom_range(1, (2 * l > 1) ? 2 * l - 1 : 1);
			else len = $urandom_range(1, 3 * l + 2);
			steady = ($urandom_range(0, 4) == 0);
			send_block(len, $urandom_range(0, len / 2), $urandom_range(0, 4) < 3,
				(1 << $urandom_range(0, 8)) - 1);
			items += len;
		end
		steady = 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		frame_report_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			reports_seen++;
			if (pending_reports.size() == 0) begin
				report_mismatch($sformatf("result with none expected, status %0d", res_ch.status));
			end else begin
				want = pending_reports.pop_front();
				if (res_ch.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						res_ch.status, want.status));
				if (res_ch.frame_start !== want.frame_start)
					report_mismatch($sformatf("frame_start %0d, expected %0d",
						res_ch.frame_start, want.frame_start));
				if (res_ch.peak_power !== want.peak_power)
					report_mismatch($sformatf("peak_power %0d, expected %0d",
						res_ch.peak_power, want.peak_power));
			end
		end
	end

	// receiver stalls: a rotating 16-bit pattern, redrawn now and then
	logic [15:0] stall_pat = '1;
	int          pat_hold = 0;
	always @(posedge clk) begin
		if (pat_hold == 0) begin
			case ($urandom_range(0, 4))
				0:       stall_pat = '1;
				1:       stall_pat = 16'h0001;
				2:       stall_pat = $urandom();
				default: stall_pat = $urandom() | $urandom();
			endcase
			if (stall_pat == '0) stall_pat = 16'h8000;
			pat_hold = $urandom_range(20, 300);
		end
		pat_hold--;
		stall_pat = {stall_pat[0], stall_pat[15:1]};
		res_ch.ready <= stall_pat[0];
	end

	initial begin : watchdog
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** frame_lag_autocorrelation_detector: FAILED **");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		smp_ch.valid = 1'b0;
		smp_ch.sample_re = '0;
		smp_ch.sample_im = '0;
		smp_ch.last_sample = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_LAG_LEN;
		cfg_ch.data = '0;
		res_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_reset_defaults();
		check_degenerate_settings();
		check_max_lag_and_wide_window();
		check_saturated_window();
		check_count_saturation();
		check_random_blocks();
		wait_quiet();

		if (mismatches == 0)
			$display("** frame_lag_autocorrelation_detector: PASSED **");
		else
			$display("** frame_lag_autocorrelation_detector: FAILED **");
		$finish;
	end

endmodule
